### design/spmv_pkg.sv
package spmv_pkg;

	localparam int COL_W   = 12;
	localparam int DATA_W  = 32;
	localparam int ROW_W   = 16;
	localparam int ACC_W   = 64;
	localparam int QUEUE_DEPTH = 4;

	// request kinds carried in the slave-side tuser
	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_START  = 2'd1;
	localparam logic [1:0] ACT_NZ     = 2'd2;
	localparam logic [1:0] ACT_FINISH = 2'd3;

	// one classified request handed from the front to the back
	typedef struct packed {
		logic [1:0]               action;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] elem;
	} spmv_entry_t;

endpackage

### design/spmv_ram.sv
module spmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/spmv_front.sv
module spmv_front #(
	parameter int VECTOR_DEPTH = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     in_action,
	input  logic [spmv_pkg::COL_W-1:0]     in_column,
	input  logic [spmv_pkg::DATA_W-1:0]    in_value,
	output logic                           push_valid,
	input  logic                           push_ready,
	output spmv_pkg::spmv_entry_t          push_entry
);

	localparam int AW = $clog2(VECTOR_DEPTH);

	logic [31:0]                   col_ext;
	logic                          in_range;
	logic                          in_acc;
	logic [AW-1:0]                 addr;
	logic [spmv_pkg::DATA_W-1:0]   rdata;

	logic                          valid_s1;
	logic [1:0]                    action_s1;
	logic [spmv_pkg::DATA_W-1:0]   value_s1;
	logic                          in_range_s1;

	assign col_ext  = {{(32 - spmv_pkg::COL_W){1'b0}}, in_column};
	assign in_range = col_ext < 32'(VECTOR_DEPTH);
	assign addr     = col_ext[AW-1:0];
	assign in_acc   = in_valid && in_ready;

	// loads end here, only the other kinds go on to the queue
	assign push_valid = valid_s1 && (action_s1 != spmv_pkg::ACT_LOAD);
	assign in_ready   = !valid_s1 || !push_valid || push_ready;

	spmv_ram #(
		.WIDTH(spmv_pkg::DATA_W),
		.DEPTH(VECTOR_DEPTH)
	) u_vec (
		.clk  (clk),
		.we   (in_acc && (in_action == spmv_pkg::ACT_LOAD) && in_range),
		.waddr(addr),
		.wdata(in_value),
		.re   (in_acc && (in_action == spmv_pkg::ACT_NZ)),
		.raddr(addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_s1   <= in_action;
			value_s1    <= in_value;
			in_range_s1 <= in_range;
		end
	end

	always_comb begin
		push_entry.action = action_s1;
		push_entry.value  = $signed(value_s1);
		push_entry.elem   = in_range_s1 ? $signed(rdata) : '0;
	end

endmodule

### design/spmv_queue.sv
module spmv_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  spmv_pkg::spmv_entry_t push_entry,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output spmv_pkg::spmv_entry_t pop_entry
);

	localparam int D  = spmv_pkg::QUEUE_DEPTH;
	localparam int PW = $clog2(D);
	localparam int CW = $clog2(D + 1);

	spmv_pkg::spmv_entry_t slot_q [D];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = count_q != CW'(D);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_entry  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(D - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(D - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

### design/spmv_back.sv
module spmv_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pop_valid,
	output logic                           pop_ready,
	input  spmv_pkg::spmv_entry_t          pop_entry,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [spmv_pkg::ROW_W-1:0]     out_row,
	output logic [spmv_pkg::DATA_W-1:0]    out_result,
	output logic                           out_sat
);

	localparam int AW = spmv_pkg::ACC_W;
	localparam int DW = spmv_pkg::DATA_W;

	logic                  adv;
	logic signed [AW-1:0]  prod_c;

	logic                  valid_s2;
	logic [1:0]            action_s2;
	logic [DW-1:0]         value_s2;
	logic [AW-1:0]         prod_s2;

	logic [AW-1:0]         acc_q;
	logic [spmv_pkg::ROW_W-1:0] row_q;
	logic                  out_valid_q;
	logic [DW-1:0]         out_result_q;
	logic                  out_sat_q;
	logic [spmv_pkg::ROW_W-1:0] out_row_q;

	logic [AW-1:0]         start_val;
	logic [AW-1:0]         scaled;
	logic [AW-DW:0]        hi_bits;
	logic                  fits;
	logic [DW-1:0]         clip_val;

	assign adv       = !out_valid_q || out_ready;
	assign pop_ready = adv;
	assign prod_c    = pop_entry.value * pop_entry.elem;

	assign start_val = {{(AW - DW){value_s2[DW-1]}}, value_s2} << FRAC_BITS;
	assign scaled    = $signed(acc_q) >>> FRAC_BITS;
	// the top bits down to the result sign must agree for no clipping
	assign hi_bits   = scaled[AW-1:DW-1];
	assign fits      = (hi_bits == '0) || (hi_bits == '1);
	assign clip_val  = scaled[AW-1] ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			acc_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s2    <= pop_valid;
			out_valid_q <= valid_s2 && (action_s2 == spmv_pkg::ACT_FINISH);
			if (valid_s2) begin
				case (action_s2)
					spmv_pkg::ACT_START: begin
						acc_q <= start_val;
					end
					spmv_pkg::ACT_NZ: begin
						acc_q <= acc_q + prod_s2;
					end
					spmv_pkg::ACT_FINISH: begin
						acc_q <= '0;
						row_q <= row_q + 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pop_valid) begin
			action_s2 <= pop_entry.action;
			value_s2  <= pop_entry.value;
			prod_s2   <= prod_c;
		end
		if (adv && valid_s2 && (action_s2 == spmv_pkg::ACT_FINISH)) begin
			out_row_q    <= row_q;
			out_result_q <= fits ? scaled[DW-1:0] : clip_val;
			out_sat_q    <= !fits;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_row    = out_row_q;
	assign out_result = out_result_q;
	assign out_sat    = out_sat_q;

endmodule

### design/csr_sparse_matrix_vector_multiply_top.sv
// csr sparse matrix times dense vector, added onto a prior result, in signed
// fixed point with FRAC_BITS fraction bits. each slave-side request carries a
// kind in tuser: load a vector element, start a row with its prior value,
// multiply-accumulate one nonzero, or finish the row. only a finish gives a
// master-side request: row number, prior value plus row sum saturated to 32
// bits, and a flag when clipping happened. one request is taken every cycle
// while the master side keeps up; the vector store is a single ram with a
// registered read, written by loads and read by nonzeros as they are taken.
// after its finish request is taken, a result passes through the ram read
// stage, the queue and the product register into the result register, which
// is loaded alongside the accumulator. a four-entry queue between the front
// and the back lets the slave side keep taking requests while a result
// waits on the master side. the vector store holds no reset
// value: a nonzero must name a column that has been loaded since reset,
// columns at or past VECTOR_DEPTH read as zero and loads to them are dropped.
module csr_sparse_matrix_vector_multiply_top #(
	parameter int VECTOR_DEPTH = 4096,
	parameter int FRAC_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // column[11:0], entry_value[43:12], zero pad
	input  logic [1:0]  s_axis_tuser,   // action[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // row_index[15:0], row_result[47:16]
	output logic [0:0]  m_axis_tuser    // saturated[0]
);

	// front to queue
	logic                  push_valid;
	logic                  push_ready;
	spmv_pkg::spmv_entry_t push_entry;

	// queue to back
	logic                  pop_valid;
	logic                  pop_ready;
	spmv_pkg::spmv_entry_t pop_entry;

	logic [spmv_pkg::ROW_W-1:0]  out_row;
	logic [spmv_pkg::DATA_W-1:0] out_result;
	logic                        out_sat;

	// front: vector store writes, element reads, request classification
	spmv_front #(
		.VECTOR_DEPTH(VECTOR_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.in_column (s_axis_tdata[11:0]),
		.in_value  (s_axis_tdata[43:12]),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry)
	);

	// short queue so the back can stall on the master side alone
	spmv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_entry(push_entry),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry)
	);

	// back: multiply, accumulate, scale and saturate on finish
	spmv_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_row   (out_row),
		.out_result(out_result),
		.out_sat   (out_sat)
	);

	assign m_axis_tdata = {out_result, out_row};
	assign m_axis_tuser = out_sat;

endmodule
